[src/sensorless_bldc_six_step_commutator_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the six-step commutator
// Shared concurrent-assertion forms, clocked on clock and muted in reset.
// ----------------------------------------------------------------------------
`ifndef SENSORLESS_BLDC_SIX_STEP_COMMUTATOR_MACROS_SVH
`define SENSORLESS_BLDC_SIX_STEP_COMMUTATOR_MACROS_SVH

// Condition holds at every edge out of reset
`define BLDC6_ASSERT_ALWAYS(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle
`define BLDC6_ASSERT_IMPLY(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Antecedent implies consequent in the next cycle
`define BLDC6_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[src/bldc6_pkg.sv]
// ----------------------------------------------------------------------------
// bldc6_pkg
// Types, register codes, reset values and the six-step drive table.
// ----------------------------------------------------------------------------
package bldc6_pkg;

   // compare selectors in the step table
   localparam logic [1:0] SEL_DUTY = 2'd0;
   localparam logic [1:0] SEL_FULL = 2'd1;
   localparam logic [1:0] SEL_ZERO = 2'd2;

   // register indexes (byte address / 4)
   localparam logic [2:0] REG_RAMP_START = 3'd0;
   localparam logic [2:0] REG_RAMP_DEC   = 3'd1;
   localparam logic [2:0] REG_RAMP_END   = 3'd2;
   localparam logic [2:0] REG_QUALIFY    = 3'd3;
   localparam logic [2:0] REG_PWM_DUTY   = 3'd4;

   localparam logic [2:0]  LAST_STEP = 3'd5;
   localparam logic [15:0] FULL_CMP  = 16'hFFFF;
   localparam logic [15:0] TICK_MAX  = 16'hFFFF;
   localparam logic [7:0]  MATCH_MAX = 8'hFF;

   // register reset values
   localparam logic [15:0] RST_RAMP_START = 16'd10000;
   localparam logic [15:0] RST_RAMP_DEC   = 16'd200;
   localparam logic [15:0] RST_RAMP_END   = 16'd100;
   localparam logic [7:0]  RST_QUALIFY    = 8'd150;
   localparam logic [15:0] RST_PWM_DUTY   = 16'd0;

   typedef struct packed {
      logic [2:0] en;
      logic [2:0] hi;
      logic [1:0] s1;
      logic [1:0] s2;
      logic [1:0] s3;
      logic [1:0] phase;
      logic       falling;
   } step_entry_type;

   typedef struct packed {
      logic [15:0] ramp_start;
      logic [15:0] ramp_dec;
      logic [15:0] ramp_end;
      logic [7:0]  qualify;
      logic [15:0] duty;
   } cfg_type;

   typedef struct packed {
      logic [2:0]  phase_enable_mask;
      logic [2:0]  phase_high_mask;
      logic [15:0] compare_one;
      logic [15:0] compare_two;
      logic [15:0] compare_three;
      logic [1:0]  sensed_phase;
      logic        sense_falling;
      logic [2:0]  next_step;
      logic        commutated;
      logic        closed_loop;
   } result_type;

   // six-step drive table; out-of-range steps fall back to step 0
   function automatic step_entry_type step_lookup(input logic [2:0] s);
      step_entry_type e;
      case (s)
         3'd1:    e = '{3'd5, 3'd1, SEL_DUTY, SEL_ZERO, SEL_FULL, 2'd2, 1'b1};
         3'd2:    e = '{3'd6, 3'd2, SEL_ZERO, SEL_DUTY, SEL_FULL, 2'd1, 1'b0};
         3'd3:    e = '{3'd3, 3'd2, SEL_FULL, SEL_DUTY, SEL_ZERO, 2'd3, 1'b1};
         3'd4:    e = '{3'd5, 3'd4, SEL_FULL, SEL_ZERO, SEL_DUTY, 2'd2, 1'b0};
         3'd5:    e = '{3'd6, 3'd4, SEL_ZERO, SEL_FULL, SEL_DUTY, 2'd1, 1'b1};
         default: e = '{3'd3, 3'd1, SEL_DUTY, SEL_FULL, SEL_ZERO, 2'd3, 1'b0};
      endcase
      return e;
   endfunction

   // resolve a compare selector to a compare value
   function automatic logic [15:0] pick_compare(input logic [1:0] sel,
                                                input logic [15:0] duty);
      logic [15:0] v;
      case (sel)
         SEL_DUTY: v = duty;
         SEL_FULL: v = FULL_CMP;
         default:  v = 16'd0;
      endcase
      return v;
   endfunction

endpackage

[src/bldc6_chan_if.sv]
// ----------------------------------------------------------------------------
// bldc6 channel interfaces
// Valid/ready channels for comparator samples and drive results.
// ----------------------------------------------------------------------------
interface bldc6_req_if;
   logic valid;
   logic ready;
   logic time_tick;
   logic comparator_level;

   modport source (output valid, output time_tick, output comparator_level, input ready);
   modport sink   (input valid, input time_tick, input comparator_level, output ready);
endinterface

interface bldc6_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  phase_enable_mask;
   logic [2:0]  phase_high_mask;
   logic [15:0] compare_one;
   logic [15:0] compare_two;
   logic [15:0] compare_three;
   logic [1:0]  sensed_phase;
   logic        sense_falling;
   logic [2:0]  next_step;
   logic        commutated;
   logic        closed_loop;

   modport source (output valid, output phase_enable_mask, output phase_high_mask,
                   output compare_one, output compare_two, output compare_three,
                   output sensed_phase, output sense_falling, output next_step,
                   output commutated, output closed_loop, input ready);
   modport sink   (input valid, input phase_enable_mask, input phase_high_mask,
                   input compare_one, input compare_two, input compare_three,
                   input sensed_phase, input sense_falling, input next_step,
                   input commutated, input closed_loop, output ready);
endinterface

[src/bldc6_core.sv]
// ----------------------------------------------------------------------------
// bldc6_core
// Commutation state: open-loop ramp timer, edge latch, zero-crossing
// qualification and the registered drive word. One sample per beat.
// ----------------------------------------------------------------------------
`include "sensorless_bldc_six_step_commutator_macros.svh"

module bldc6_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  beat,
   input  logic                  time_tick,
   input  logic                  comparator_level,
   input  bldc6_pkg::cfg_type    cfg,
   input  logic                  start_wr,
   output bldc6_pkg::result_type result
);

   logic [2:0]  step_ff, step_in;
   logic [15:0] ramp_ff, ramp_in;
   logic [15:0] period_ff, period_in;
   logic [15:0] tick_ff, tick_in;
   logic        sensing_ff, sensing_in;
   logic        latched_ff, latched_in;
   logic        qual_ff, qual_in;
   logic [7:0]  match_ff, match_in;
   logic        level_ff, level_in;
   logic [2:0]  en_ff, en_in;
   logic [2:0]  hi_ff, hi_in;
   logic [15:0] c1_ff, c1_in;
   logic [15:0] c2_ff, c2_in;
   logic [15:0] c3_ff, c3_in;
   logic [1:0]  phase_ff, phase_in;
   logic        falling_ff, falling_in;

   logic [2:0]  step_cur;
   logic [2:0]  step_adv;
   logic [15:0] tick_inc;
   logic        expire;
   logic        open_comm;
   logic        go_closed;
   logic        qual_act;
   logic [7:0]  need;
   logic [7:0]  match_inc;
   logic        closed_comm;
   logic        did;
   logic        edge_seen;
   bldc6_pkg::step_entry_type entry;

   // step decode and table lookup
   assign step_cur = (step_ff <= bldc6_pkg::LAST_STEP) ? step_ff : 3'd0;
   assign step_adv = (step_cur == bldc6_pkg::LAST_STEP) ? 3'd0 : step_cur + 3'd1;
   assign entry    = bldc6_pkg::step_lookup(step_cur);

   // open-loop timer
   assign tick_inc  = (tick_ff != bldc6_pkg::TICK_MAX) ? tick_ff + 16'd1 : tick_ff;
   assign expire    = !sensing_ff && time_tick && (tick_inc >= period_ff);
   assign open_comm = expire && (ramp_ff > cfg.ramp_end);
   assign go_closed = expire && !open_comm;

   // zero-crossing qualification
   assign qual_act    = sensing_ff && (qual_ff || latched_ff);
   assign need        = (cfg.qualify == 8'd0) ? 8'd1 : cfg.qualify;
   assign match_inc   = ((comparator_level == step_ff[0]) && (match_ff != bldc6_pkg::MATCH_MAX))
                        ? match_ff + 8'd1 : match_ff;
   assign closed_comm = qual_act && (match_inc >= need);
   assign did         = open_comm || closed_comm;

   // edge of the selected polarity
   assign edge_seen = falling_ff ? (level_ff && !comparator_level)
                                 : (!level_ff && comparator_level);

   // next state
   always_comb begin
      step_in    = step_ff;
      ramp_in    = ramp_ff;
      period_in  = period_ff;
      tick_in    = tick_ff;
      sensing_in = sensing_ff;
      latched_in = latched_ff;
      qual_in    = qual_ff;
      match_in   = match_ff;
      level_in   = level_ff;
      en_in      = en_ff;
      hi_in      = hi_ff;
      c1_in      = c1_ff;
      c2_in      = c2_ff;
      c3_in      = c3_ff;
      phase_in   = phase_ff;
      falling_in = falling_ff;
      if (beat) begin
         level_in = comparator_level;
         if (!sensing_ff && time_tick) begin
            tick_in = expire ? 16'd0 : tick_inc;
         end
         if (open_comm) begin
            period_in = ramp_ff;
            ramp_in   = (ramp_ff > cfg.ramp_dec) ? ramp_ff - cfg.ramp_dec : 16'd0;
         end
         if (go_closed) begin
            sensing_in = 1'b1;
         end
         if (qual_act) begin
            qual_in  = 1'b1;
            match_in = match_inc;
         end
         if (did) begin
            step_in    = step_adv;
            latched_in = 1'b0;
            qual_in    = 1'b0;
            match_in   = 8'd0;
            en_in      = entry.en;
            hi_in      = entry.hi;
            c1_in      = bldc6_pkg::pick_compare(entry.s1, cfg.duty);
            c2_in      = bldc6_pkg::pick_compare(entry.s2, cfg.duty);
            c3_in      = bldc6_pkg::pick_compare(entry.s3, cfg.duty);
            phase_in   = entry.phase;
            falling_in = entry.falling;
         end else if (edge_seen) begin
            latched_in = 1'b1;
         end
      end else if (start_wr && !sensing_ff) begin
         // reload the ramp while still in open loop
         ramp_in   = cfg.ramp_start;
         period_in = cfg.ramp_start;
         tick_in   = 16'd0;
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff    <= 3'd0;
         ramp_ff    <= bldc6_pkg::RST_RAMP_START;
         period_ff  <= bldc6_pkg::RST_RAMP_START;
         tick_ff    <= 16'd0;
         sensing_ff <= 1'b0;
         latched_ff <= 1'b0;
         qual_ff    <= 1'b0;
         match_ff   <= 8'd0;
         level_ff   <= 1'b0;
         en_ff      <= 3'd0;
         hi_ff      <= 3'd0;
         c1_ff      <= 16'd0;
         c2_ff      <= 16'd0;
         c3_ff      <= 16'd0;
         phase_ff   <= 2'd0;
         falling_ff <= 1'b0;
      end else begin
         step_ff    <= step_in;
         ramp_ff    <= ramp_in;
         period_ff  <= period_in;
         tick_ff    <= tick_in;
         sensing_ff <= sensing_in;
         latched_ff <= latched_in;
         qual_ff    <= qual_in;
         match_ff   <= match_in;
         level_ff   <= level_in;
         en_ff      <= en_in;
         hi_ff      <= hi_in;
         c1_ff      <= c1_in;
         c2_ff      <= c2_in;
         c3_ff      <= c3_in;
         phase_ff   <= phase_in;
         falling_ff <= falling_in;
      end
   end

   // result of this beat, after the update
   always_comb begin
      result.phase_enable_mask = en_in;
      result.phase_high_mask   = hi_in;
      result.compare_one       = c1_in;
      result.compare_two       = c2_in;
      result.compare_three     = c3_in;
      result.sensed_phase      = phase_in;
      result.sense_falling     = falling_in;
      result.next_step         = step_in;
      result.commutated        = beat && did;
      result.closed_loop       = sensing_in;
   end

   `BLDC6_ASSERT_NEXT(a_closed_loop_holds, sensing_ff, sensing_ff, "closed loop dropped")
   `BLDC6_ASSERT_IMPLY(a_qual_needs_sensing, qual_ff, sensing_ff, "qualifying in open loop")
   `BLDC6_ASSERT_IMPLY(a_match_needs_qual, match_ff != 8'd0, qual_ff, "stray match count")
   `BLDC6_ASSERT_NEXT(a_drive_holds, !(beat && did), $stable(en_ff) && $stable(phase_ff),
                      "drive changed without commutation")
   `BLDC6_ASSERT_ALWAYS(a_step_range, step_ff <= bldc6_pkg::LAST_STEP, "step out of range")

endmodule

[src/sensorless_bldc_six_step_commutator.sv]
// ----------------------------------------------------------------------------
// sensorless_bldc_six_step_commutator
// Sensorless six-step commutator: open-loop ramp start, then back-EMF
// zero-crossing commutation, with an APB-style register port.
//
//   channel   direction  handshake        payload
//   req_bus   in         valid / ready    time_tick, comparator_level
//   rsp_bus   out        valid / ready    drive masks, compares, step, flags
//   csr_*     in         psel / penable   five config registers at 4*i
//
// One sample per cycle unless the output register is stalled; its result
// appears in the output register the next cycle. Core state updates on a
// sample beat or a ramp start write. A stalled result holds in the output
// register; a new sample is taken in the same cycle the held result is taken.
// Reset is synchronous, active high; all phases off, ramp at its start value.
// ----------------------------------------------------------------------------
module sensorless_bldc_six_step_commutator (
   input  logic        clock,
   input  logic        reset,
   bldc6_req_if.sink   req_bus,
   bldc6_rsp_if.source rsp_bus,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   bldc6_pkg::cfg_type    cfg_ff, cfg_in;
   bldc6_pkg::result_type result;
   bldc6_pkg::result_type rsp_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  beat;
   logic                  csr_wr;
   logic                  start_wr;
   logic [2:0]            reg_idx;

   // take a sample when the output register is free or draining
   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign beat          = req_bus.valid && req_bus.ready;

   // register write decode
   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[4:2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign start_wr   = csr_wr && (reg_idx == bldc6_pkg::REG_RAMP_START);

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr) begin
         case (reg_idx)
            bldc6_pkg::REG_RAMP_START: cfg_in.ramp_start = csr_pwdata[15:0];
            bldc6_pkg::REG_RAMP_DEC:   cfg_in.ramp_dec   = csr_pwdata[15:0];
            bldc6_pkg::REG_RAMP_END:   cfg_in.ramp_end   = csr_pwdata[15:0];
            bldc6_pkg::REG_QUALIFY:    cfg_in.qualify    = csr_pwdata[7:0];
            bldc6_pkg::REG_PWM_DUTY:   cfg_in.duty       = csr_pwdata[15:0];
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   // register read mux
   always_comb begin
      case (reg_idx)
         bldc6_pkg::REG_RAMP_START: csr_prdata = {16'd0, cfg_ff.ramp_start};
         bldc6_pkg::REG_RAMP_DEC:   csr_prdata = {16'd0, cfg_ff.ramp_dec};
         bldc6_pkg::REG_RAMP_END:   csr_prdata = {16'd0, cfg_ff.ramp_end};
         bldc6_pkg::REG_QUALIFY:    csr_prdata = {24'd0, cfg_ff.qualify};
         bldc6_pkg::REG_PWM_DUTY:   csr_prdata = {16'd0, cfg_ff.duty};
         default:                   csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ramp_start <= bldc6_pkg::RST_RAMP_START;
         cfg_ff.ramp_dec   <= bldc6_pkg::RST_RAMP_DEC;
         cfg_ff.ramp_end   <= bldc6_pkg::RST_RAMP_END;
         cfg_ff.qualify    <= bldc6_pkg::RST_QUALIFY;
         cfg_ff.duty       <= bldc6_pkg::RST_PWM_DUTY;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // core sees the register values including a write in progress
   bldc6_core u_core (
      .clock            (clock),
      .reset            (reset),
      .beat             (beat),
      .time_tick        (req_bus.time_tick),
      .comparator_level (req_bus.comparator_level),
      .cfg              (cfg_in),
      .start_wr         (start_wr),
      .result           (result)
   );

   // output register: load on a sample beat, drop valid once taken
   assign rsp_valid_in = beat || (rsp_valid_ff && !rsp_bus.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (beat) begin
         rsp_ff <= result;
      end
   end

   assign rsp_bus.valid             = rsp_valid_ff;
   assign rsp_bus.phase_enable_mask = rsp_ff.phase_enable_mask;
   assign rsp_bus.phase_high_mask   = rsp_ff.phase_high_mask;
   assign rsp_bus.compare_one       = rsp_ff.compare_one;
   assign rsp_bus.compare_two       = rsp_ff.compare_two;
   assign rsp_bus.compare_three     = rsp_ff.compare_three;
   assign rsp_bus.sensed_phase      = rsp_ff.sensed_phase;
   assign rsp_bus.sense_falling     = rsp_ff.sense_falling;
   assign rsp_bus.next_step         = rsp_ff.next_step;
   assign rsp_bus.commutated        = rsp_ff.commutated;
   assign rsp_bus.closed_loop       = rsp_ff.closed_loop;

endmodule

[tb/sv/tb_sensorless_bldc_six_step_commutator.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sensorless_bldc_six_step_commutator
// Drives comparator samples through the commutator and predicts every drive
// result with a cycle-free model of the open-loop ramp, the closed-loop
// zero-crossing qualifier and the six-step table. Sample and result sides
// idle at random; registers are rewritten between phases while the block is
// quiet.
// ----------------------------------------------------------------------------
module tb_sensorless_bldc_six_step_commutator;

   localparam int STALL_LIMIT = 2000;
   localparam int HOLD_CYCLES = 64;
   localparam int MAX_GAP     = 17;
   localparam int REPORT_MAX  = 10;

   // enables, high side, compare selectors, sensed phase, edge polarity
   localparam bldc6_pkg::step_entry_type COMMUTATION_TABLE [6] = '{
      '{3'd3, 3'd1, bldc6_pkg::SEL_DUTY, bldc6_pkg::SEL_FULL, bldc6_pkg::SEL_ZERO,
        2'd3, 1'b0},
      '{3'd5, 3'd1, bldc6_pkg::SEL_DUTY, bldc6_pkg::SEL_ZERO, bldc6_pkg::SEL_FULL,
        2'd2, 1'b1},
      '{3'd6, 3'd2, bldc6_pkg::SEL_ZERO, bldc6_pkg::SEL_DUTY, bldc6_pkg::SEL_FULL,
        2'd1, 1'b0},
      '{3'd3, 3'd2, bldc6_pkg::SEL_FULL, bldc6_pkg::SEL_DUTY, bldc6_pkg::SEL_ZERO,
        2'd3, 1'b1},
      '{3'd5, 3'd4, bldc6_pkg::SEL_FULL, bldc6_pkg::SEL_ZERO, bldc6_pkg::SEL_DUTY,
        2'd2, 1'b0},
      '{3'd6, 3'd4, bldc6_pkg::SEL_ZERO, bldc6_pkg::SEL_FULL, bldc6_pkg::SEL_DUTY,
        2'd1, 1'b1}
   };

   logic        clock;
   logic        reset;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [4:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   bldc6_req_if req_bus ();
   bldc6_rsp_if rsp_bus ();

   sensorless_bldc_six_step_commutator dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // motor state as the testbench sees it
   bldc6_pkg::cfg_type    cfg_now;
   logic [2:0]            step_ptr;
   logic [15:0]           ramp_val;
   logic [15:0]           period_val;
   logic [15:0]           tick_cnt;
   logic [7:0]            match_cnt;
   bit                    sensing;
   bit                    edge_held;
   bit                    qualifying;
   bit                    prev_level;
   bldc6_pkg::result_type drive_now;
   bldc6_pkg::result_type drive_expect_q [$];

   int unsigned fault_count;
   int unsigned idle_cycles;
   int unsigned samples_sent;
   bit          send_burst;
   bit          take_burst;
   bit          hold_off_req;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // drive prediction
   // ---------------------------------------------------------------------
   function automatic logic [15:0] compare_for(input logic [1:0] sel);
      case (sel)
         bldc6_pkg::SEL_DUTY: return cfg_now.duty;
         bldc6_pkg::SEL_FULL: return bldc6_pkg::FULL_CMP;
         default:             return 16'd0;
      endcase
   endfunction

   // apply the current step's table entry, advance the step, drop the latch
   function automatic void commutate_model();
      bldc6_pkg::step_entry_type e;
      logic [2:0]                s;
      s = (step_ptr > bldc6_pkg::LAST_STEP) ? 3'd0 : step_ptr;
      e = COMMUTATION_TABLE[s];
      drive_now.phase_enable_mask = e.en;
      drive_now.phase_high_mask   = e.hi;
      drive_now.compare_one       = compare_for(e.s1);
      drive_now.compare_two       = compare_for(e.s2);
      drive_now.compare_three     = compare_for(e.s3);
      drive_now.sensed_phase      = e.phase;
      drive_now.sense_falling     = e.falling;
      step_ptr   = (s == bldc6_pkg::LAST_STEP) ? 3'd0 : s + 3'd1;
      edge_held  = 1'b0;
      qualifying = 1'b0;
      match_cnt  = 8'd0;
   endfunction

   // advance the motor state by one sample and return the drive it yields
   function automatic bldc6_pkg::result_type predict_drive(input bit tick,
                                                           input bit level);
      bldc6_pkg::result_type r;
      bit                    was_held;
      bit                    edge_hit;
      bit                    fired;
      logic [7:0]            need;
      was_held = edge_held;
      edge_hit = drive_now.sense_falling ? (prev_level && !level)
                                         : (!prev_level && level);
      fired = 1'b0;
      if (!sensing) begin
         // open loop: the timer sets the pace
         if (tick) begin
            if (tick_cnt < bldc6_pkg::TICK_MAX) tick_cnt++;
            if (tick_cnt >= period_val) begin
               tick_cnt = 16'd0;
               if (ramp_val > cfg_now.ramp_end) begin
                  commutate_model();
                  fired      = 1'b1;
                  period_val = ramp_val;
                  ramp_val   = (ramp_val > cfg_now.ramp_dec) ?
                               ramp_val - cfg_now.ramp_dec : 16'd0;
               end else begin
                  sensing = 1'b1;
               end
            end
         end
      end else if (qualifying || was_held) begin
         // closed loop: count samples at the level the next step expects
         need       = (cfg_now.qualify == 8'd0) ? 8'd1 : cfg_now.qualify;
         qualifying = 1'b1;
         if (level == step_ptr[0] && match_cnt < bldc6_pkg::MATCH_MAX) match_cnt++;
         if (match_cnt >= need) begin
            commutate_model();
            fired = 1'b1;
         end
      end
      if (!fired && edge_hit) edge_held = 1'b1;
      prev_level    = level;
      r             = drive_now;
      r.next_step   = step_ptr;
      r.commutated  = fired;
      r.closed_loop = sensing;
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // checking
   // ---------------------------------------------------------------------
   function automatic void flag_fault(input string msg);
      fault_count++;
      if (fault_count <= REPORT_MAX) $display("%0t: %s", $time, msg);
   endfunction

   function automatic void check_field(input string name, input logic [15:0] want,
                                       input logic [15:0] got);
      if (got !== want)
         flag_fault($sformatf("%s expected %0h, got %0h", name, want, got));
   endfunction

   // compare each result beat with the oldest prediction, then predict
   always @(posedge clock) begin : beat_monitor
      bldc6_pkg::result_type got;
      bldc6_pkg::result_type want;
      if (reset === 1'b0) begin
         if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            got = {rsp_bus.phase_enable_mask, rsp_bus.phase_high_mask,
                   rsp_bus.compare_one, rsp_bus.compare_two, rsp_bus.compare_three,
                   rsp_bus.sensed_phase, rsp_bus.sense_falling, rsp_bus.next_step,
                   rsp_bus.commutated, rsp_bus.closed_loop};
            if (drive_expect_q.size() == 0) begin
               flag_fault("result beat with no sample pending");
            end else begin
               want = drive_expect_q.pop_front();
               check_field("phase_enable_mask", 16'(want.phase_enable_mask),
                           16'(got.phase_enable_mask));
               check_field("phase_high_mask", 16'(want.phase_high_mask),
                           16'(got.phase_high_mask));
               check_field("compare_one", want.compare_one, got.compare_one);
               check_field("compare_two", want.compare_two, got.compare_two);
               check_field("compare_three", want.compare_three, got.compare_three);
               check_field("sensed_phase", 16'(want.sensed_phase),
                           16'(got.sensed_phase));
               check_field("sense_falling", 16'(want.sense_falling),
                           16'(got.sense_falling));
               check_field("next_step", 16'(want.next_step), 16'(got.next_step));
               check_field("commutated", 16'(want.commutated), 16'(got.commutated));
               check_field("closed_loop", 16'(want.closed_loop), 16'(got.closed_loop));
            end
         end
         if (req_bus.valid === 1'b1 && req_bus.ready === 1'b1)
            drive_expect_q.push_back(predict_drive(req_bus.time_tick,
                                                   req_bus.comparator_level));
      end
   end

   // end the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset !== 1'b0 || (req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
          (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) ||
          (csr_psel === 1'b1 && csr_penable === 1'b1)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("tb_sensorless_bldc_six_step_commutator: FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------
   // result side: random stalls, bursts, and a long hold-off on each request
   // ---------------------------------------------------------------------
   initial begin : result_sink
      int gap;
      rsp_bus.ready <= 1'b0;
      do @(posedge clock); while (reset !== 1'b0);
      forever begin
         if (hold_off_req) begin
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_off_req = 1'b0;
         end
         if ($urandom_range(0, 39) == 0) take_burst = !take_burst;
         gap = take_burst ? 0 : $urandom_range(0, MAX_GAP);
         if (gap > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (rsp_bus.valid !== 1'b1 || rsp_bus.ready !== 1'b1);
      end
   end

   // ---------------------------------------------------------------------
   // sample side and register port
   // ---------------------------------------------------------------------
   task automatic send_sample(input bit tick, input bit level);
      int gap;
      if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
      gap = send_burst ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid            <= 1'b1;
      req_bus.time_tick        <= tick;
      req_bus.comparator_level <= level;
      do @(posedge clock); while (req_bus.valid !== 1'b1 || req_bus.ready !== 1'b1);
      samples_sent++;
   endtask

   // stop offering samples and wait for every pending result
   task automatic settle();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (drive_expect_q.size() != 0) @(posedge clock);
   endtask

   // setup then access cycle; mirror the write into the model afterwards
   task automatic csr_write(input logic [2:0] idx, input logic [31:0] val);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         bldc6_pkg::REG_RAMP_START: begin
            cfg_now.ramp_start = val[15:0];
            // a new start value restarts the ramp only before closed loop
            if (!sensing) begin
               ramp_val   = val[15:0];
               period_val = val[15:0];
               tick_cnt   = 16'd0;
            end
         end
         bldc6_pkg::REG_RAMP_DEC: cfg_now.ramp_dec = val[15:0];
         bldc6_pkg::REG_RAMP_END: cfg_now.ramp_end = val[15:0];
         bldc6_pkg::REG_QUALIFY:  cfg_now.qualify  = val[7:0];
         bldc6_pkg::REG_PWM_DUTY: cfg_now.duty     = val[15:0];
         default: ;
      endcase
   endtask

   // one back-EMF crossing: pre-edge level, edge, then the qualifying level
   task automatic drive_crossing(input bit noisy);
      bit fall;
      int need;
      fall = drive_now.sense_falling;
      need = (cfg_now.qualify == 8'd0) ? 1 : int'(cfg_now.qualify);
      repeat ($urandom_range(1, 3)) send_sample(1'($urandom_range(0, 1)), fall);
      repeat (need + $urandom_range(0, 2))
         send_sample(1'($urandom_range(0, 1)),
                     (noisy && $urandom_range(0, 9) == 0) ? fall : !fall);
   endtask

   // ---------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------
   // all phases off after reset; a high first level reads as a rising edge
   task automatic test_reset_state();
      send_sample(1'b0, 1'b1);
      send_sample(1'b1, 1'b1);
      send_sample(1'b1, 1'b0);
      send_sample(1'b0, 1'b0);
   endtask

   // short fixed period walks through all six table entries
   task automatic test_commutation_table();
      settle();
      csr_write(bldc6_pkg::REG_PWM_DUTY, 32'h0000_FFFF);
      csr_write(bldc6_pkg::REG_RAMP_DEC, 32'd0);
      csr_write(bldc6_pkg::REG_RAMP_END, 32'd0);
      csr_write(bldc6_pkg::REG_RAMP_START, 32'd2);
      repeat (12) send_sample(1'b1, 1'($urandom_range(0, 1)));
   endtask

   // rewrite the start value mid-count: widest, zero without ticks, short
   task automatic test_ramp_start_reload();
      settle();
      csr_write(bldc6_pkg::REG_PWM_DUTY, 32'd0);
      csr_write(bldc6_pkg::REG_RAMP_START, 32'h0000_FFFF);
      repeat (3) send_sample(1'b1, 1'($urandom_range(0, 1)));
      settle();
      csr_write(bldc6_pkg::REG_RAMP_START, 32'd0);
      repeat (2) send_sample(1'b0, 1'($urandom_range(0, 1)));
      settle();
      csr_write(bldc6_pkg::REG_RAMP_START, 32'd4);
      repeat (4) send_sample(1'b1, 1'($urandom_range(0, 1)));
   endtask

   // random ticks against flat and slowly shrinking periods
   task automatic test_open_loop_timing();
      int seg;
      int i;
      for (seg = 0; seg < 3; seg++) begin
         settle();
         csr_write(bldc6_pkg::REG_PWM_DUTY, $urandom_range(0, 16'hFFFF));
         csr_write(bldc6_pkg::REG_RAMP_DEC, (seg == 1) ? 32'd1 : 32'd0);
         csr_write(bldc6_pkg::REG_RAMP_START, (seg == 1) ? $urandom_range(40, 70)
                                                         : $urandom_range(1, 12));
         for (i = 0; i < 110; i++) begin
            if (seg == 0 && i == 40) hold_off_req = 1'b1;
            send_sample($urandom_range(0, 3) != 0, 1'($urandom_range(0, 1)));
         end
      end
   endtask

   // ramp down past saturation at zero and hand over to closed loop
   task automatic test_ramp_to_closed_loop();
      int guard;
      settle();
      csr_write(bldc6_pkg::REG_RAMP_DEC, 32'd7);
      csr_write(bldc6_pkg::REG_RAMP_START, 32'd20);
      guard = 0;
      while (!sensing && guard < 400) begin
         send_sample($urandom_range(0, 7) != 0, 1'($urandom_range(0, 1)));
         guard++;
      end
      repeat (10) send_sample(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
   endtask

   // mostly clean crossings with random noise, across qualify settings
   task automatic test_zero_crossing_tracking();
      int          seg;
      int unsigned target;
      logic [31:0] qual;
      for (seg = 0; seg < 5; seg++) begin
         settle();
         case (seg)
            0:       qual = 32'd1;
            1:       qual = 32'd0;
            default: qual = $urandom_range(2, 10);
         endcase
         csr_write(bldc6_pkg::REG_QUALIFY, qual);
         csr_write(bldc6_pkg::REG_PWM_DUTY, $urandom_range(0, 16'hFFFF));
         // timer registers have no effect once sensing drives commutation
         if (seg == 2) begin
            csr_write(bldc6_pkg::REG_RAMP_START, $urandom_range(1, 16'hFFFF));
            csr_write(bldc6_pkg::REG_RAMP_DEC, 32'h0000_FFFF);
            csr_write(bldc6_pkg::REG_RAMP_END, 32'h0000_FFFF);
         end
         if (seg == 3) hold_off_req = 1'b1;
         target = samples_sent + 120;
         while (samples_sent < target) begin
            if ($urandom_range(0, 4) != 0)
               drive_crossing(1'b1);
            else
               repeat ($urandom_range(1, 6))
                  send_sample(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
         end
      end
   endtask

   // widest qualify count: one clean crossing all the way through
   task automatic test_qualify_limit();
      settle();
      csr_write(bldc6_pkg::REG_QUALIFY, 32'd255);
      drive_crossing(1'b0);
      repeat (4) send_sample(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
   endtask

   // ---------------------------------------------------------------------
   // sequence
   // ---------------------------------------------------------------------
   initial begin : run
      reset                    <= 1'b1;
      req_bus.valid            <= 1'b0;
      req_bus.time_tick        <= 1'b0;
      req_bus.comparator_level <= 1'b0;
      csr_psel                 <= 1'b0;
      csr_penable              <= 1'b0;
      csr_pwrite               <= 1'b0;
      csr_paddr                <= '0;
      csr_pwdata               <= '0;
      cfg_now    = '{bldc6_pkg::RST_RAMP_START, bldc6_pkg::RST_RAMP_DEC,
                     bldc6_pkg::RST_RAMP_END, bldc6_pkg::RST_QUALIFY,
                     bldc6_pkg::RST_PWM_DUTY};
      step_ptr   = 3'd0;
      ramp_val   = bldc6_pkg::RST_RAMP_START;
      period_val = bldc6_pkg::RST_RAMP_START;
      tick_cnt   = 16'd0;
      match_cnt  = 8'd0;
      sensing    = 1'b0;
      edge_held  = 1'b0;
      qualifying = 1'b0;
      prev_level = 1'b0;
      drive_now  = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_commutation_table();
      test_ramp_start_reload();
      test_open_loop_timing();
      test_ramp_to_closed_loop();
      test_zero_crossing_tracking();
      test_qualify_limit();

      // drain, then give stray beats a chance to show up
      settle();
      repeat (4) @(posedge clock);
      if (fault_count == 0 && drive_expect_q.size() == 0)
         $display("tb_sensorless_bldc_six_step_commutator: PASS");
      else
         $display("tb_sensorless_bldc_six_step_commutator: FAIL");
      $finish;
   end

endmodule
